### rtl/dad_pkg.sv
package dad_pkg;

  // input item of one transfer
  typedef struct packed {
    logic [4:0]  start_day;
    logic [3:0]  start_month;
    logic [13:0] start_year;
    logic [15:0] days_to_add;
  } req_t;

  // result item of one transfer
  typedef struct packed {
    logic [4:0]  result_day;
    logic [3:0]  result_month;
    logic [13:0] result_year;
    logic        input_invalid;
  } res_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_DONE
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic check;
    logic walk;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic invalid;
    logic walk_done;
  } sts_t;

  localparam int unsigned DayW   = 17;  // start day plus count
  localparam int unsigned YearW  = 15;  // room for years walked past 16383
  localparam int unsigned Cyc400W = 9;  // year position inside a 400 year cycle
  localparam int unsigned Cycle400 = 400;
  localparam int unsigned Cycle100 = 100;

  // month length, zero for codes that are no month
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // leap test on the year position inside the 400 year cycle
  function automatic logic is_leap(input logic [Cyc400W-1:0] r);
    logic div4;
    logic century;
    div4    = (r[1:0] == 2'b00);
    century = (r == Cyc400W'(Cycle100)) || (r == Cyc400W'(2 * Cycle100)) ||
              (r == Cyc400W'(3 * Cycle100));
    return div4 && !century;
  endfunction

  // position of the following year inside the cycle
  function automatic logic [Cyc400W-1:0] next_cyc(input logic [Cyc400W-1:0] r);
    logic [Cyc400W-1:0] n;
    n = (r == Cyc400W'(Cycle400 - 1)) ? '0 : r + 1'b1;
    return n;
  endfunction

  // year mod 400 by restoring subtraction of scaled multiples
  function automatic logic [Cyc400W-1:0] year_mod400(input logic [13:0] y);
    logic [13:0] r;
    r = y;
    for (int k = 5; k >= 0; k--) begin
      if (r >= 14'(Cycle400 << k)) begin
        r = r - 14'(Cycle400 << k);
      end
    end
    return r[Cyc400W-1:0];
  endfunction

endpackage

### rtl/dad_ctrl.sv
module dad_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  dad_pkg::sts_t sts_i,
  output dad_pkg::cmd_t cmd_o,
  output logic          busy_o,
  output logic          done_o
);

  dad_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dad_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dad_pkg::ST_IDLE: begin
        if (start_i) state_d = dad_pkg::ST_CHECK;
      end
      dad_pkg::ST_CHECK: begin
        state_d = sts_i.invalid ? dad_pkg::ST_DONE : dad_pkg::ST_WALK;
      end
      dad_pkg::ST_WALK: begin
        if (sts_i.walk_done) state_d = dad_pkg::ST_DONE;
      end
      dad_pkg::ST_DONE: begin
        state_d = dad_pkg::ST_IDLE;
      end
      default: begin
        state_d = dad_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    done_o = 1'b0;
    case (state_q)
      dad_pkg::ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      dad_pkg::ST_CHECK: begin
        cmd_o.check = 1'b1;
      end
      dad_pkg::ST_WALK: begin
        cmd_o.walk = 1'b1;
      end
      dad_pkg::ST_DONE: begin
        done_o = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

endmodule

### rtl/dad_datapath.sv
module dad_datapath (
  input  logic          clk_i,
  input  dad_pkg::req_t req_i,
  input  dad_pkg::cmd_t cmd_i,
  output dad_pkg::sts_t sts_o,
  output dad_pkg::res_t res_o
);

  logic [dad_pkg::DayW-1:0]    day_q, day_d;
  logic [3:0]                  mon_q, mon_d;
  logic [dad_pkg::YearW-1:0]   year_q, year_d;
  logic [dad_pkg::Cyc400W-1:0] cyc_q, cyc_d;
  logic [15:0]                 cnt_q, cnt_d;
  logic                        inv_q, inv_d;

  logic [dad_pkg::Cyc400W-1:0] cyc_next;
  logic                        leap_cur;
  logic                        leap_next;
  logic [4:0]                  mlen;
  logic [8:0]                  ylen;
  logic                        year_step;
  logic                        month_step;
  logic                        invalid;

  // calendar lookups on the current date
  assign cyc_next  = dad_pkg::next_cyc(cyc_q);
  assign leap_cur  = dad_pkg::is_leap(cyc_q);
  assign leap_next = dad_pkg::is_leap(cyc_next);
  assign mlen      = dad_pkg::month_len(mon_q, leap_cur);

  // twelve months from here hold a leap day if this february or next one does
  assign ylen = (mon_q <= 4'd2) ? (leap_cur ? 9'd366 : 9'd365) :
                                  (leap_next ? 9'd366 : 9'd365);

  assign year_step  = day_q > dad_pkg::DayW'(ylen);
  assign month_step = day_q > dad_pkg::DayW'(mlen);

  // start date range check
  assign invalid = (mon_q == 4'd0) || (mon_q > 4'd12) || (day_q == '0) || month_step;

  assign sts_o.invalid   = invalid;
  assign sts_o.walk_done = !year_step && !month_step;

  // next datapath values
  always_comb begin
    day_d  = day_q;
    mon_d  = mon_q;
    year_d = year_q;
    cyc_d  = cyc_q;
    cnt_d  = cnt_q;
    inv_d  = inv_q;
    if (cmd_i.load) begin
      day_d  = dad_pkg::DayW'(req_i.start_day);
      mon_d  = req_i.start_month;
      year_d = dad_pkg::YearW'(req_i.start_year);
      cyc_d  = dad_pkg::year_mod400(req_i.start_year);
      cnt_d  = req_i.days_to_add;
      inv_d  = 1'b0;
    end else if (cmd_i.check) begin
      inv_d = invalid;
      if (!invalid) day_d = day_q + dad_pkg::DayW'(cnt_q);
    end else if (cmd_i.walk) begin
      if (year_step) begin
        // skip a whole year at once
        day_d  = day_q - dad_pkg::DayW'(ylen);
        year_d = year_q + 1'b1;
        cyc_d  = cyc_next;
      end else if (month_step) begin
        day_d = day_q - dad_pkg::DayW'(mlen);
        if (mon_q == 4'd12) begin
          mon_d  = 4'd1;
          year_d = year_q + 1'b1;
          cyc_d  = cyc_next;
        end else begin
          mon_d = mon_q + 1'b1;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    day_q  <= day_d;
    mon_q  <= mon_d;
    year_q <= year_d;
    cyc_q  <= cyc_d;
    cnt_q  <= cnt_d;
    inv_q  <= inv_d;
  end

  // result fields, cleared for a bad start date
  always_comb begin
    res_o = '0;
    res_o.input_invalid = inv_q;
    if (!inv_q) begin
      res_o.result_day   = day_q[4:0];
      res_o.result_month = mon_q;
      res_o.result_year  = year_q[13:0];
    end
  end

endmodule

### rtl/date_add_days_unit.sv
// a start transfer goes through a check of the start date, the walk and then done_o; a bad
// start date goes from the check straight to done_o; one item is taken at a time and the
// next start is taken the cycle after done_o; the walk subtracts one year or one month per
// cycle; reset clears the controller to idle; results are never stalled by the receiver
module date_add_days_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  dad_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output dad_pkg::res_t res_o
);

  dad_pkg::cmd_t cmd;
  dad_pkg::sts_t sts;

  // sequencer
  dad_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // date registers and calendar arithmetic
  dad_datapath u_dp (
    .clk_i (clk_i),
    .req_i (req_i),
    .cmd_i (cmd),
    .sts_o (sts),
    .res_o (res_o)
  );

endmodule

### rtl/dad_checker.sv
module dad_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input dad_pkg::req_t req_i,
  input logic          busy_o,
  input logic          done_o,
  input dad_pkg::res_t res_o
);

  // a result only shows up while an item is in flight
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("done without busy");

  // an accepted start makes the unit busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("start transfer not taken");

  // one result per item, then back to idle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy_o))
    else $error("done strobe longer than one cycle");

  // a bad start date gives an all-zero date
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.input_invalid) |->
      (res_o.result_day == '0 && res_o.result_month == '0 && res_o.result_year == '0))
    else $error("invalid result carries a date");

  // a good result is a real day and month
  a_valid_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.input_invalid) |->
      (res_o.result_day != '0 && res_o.result_month != '0 && res_o.result_month <= 4'd12))
    else $error("result date out of range");

endmodule

bind date_add_days_unit dad_checker u_dad_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .req_i   (req_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .res_o   (res_o)
);
